FILE: rtl/core/anisotropic_diffusion_pass_core_defines.svh
// assertion macros used by the checker of the diffusion core
`ifndef ANISOTROPIC_DIFFUSION_PASS_CORE_DEFINES_SVH
`define ANISOTROPIC_DIFFUSION_PASS_CORE_DEFINES_SVH

// antecedent and consequent in the same cycle, quiet during reset
`define ADP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the cycle after the antecedent, quiet during reset
`define ADP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// what must hold in the cycle after reset
`define ADP_ASSERT_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/adp_pkg.sv
package adp_pkg;

   localparam int PIX_W       = 8;
   localparam int FLUX_W      = 18;
   localparam int SUM_W       = 29;
   localparam int DIV_SHIFT   = 17;
   localparam int QV_W        = 10;
   localparam int QP_W        = 20;
   localparam int RECIP_SHIFT = 11;

   localparam logic [QV_W-1:0] RECIP_3 = 10'd683;
   localparam logic [QV_W-1:0] CLAMP_V = 10'd768;

   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 12;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 12;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_MIN    = 11'd3;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_MIN   = 12'd3;

   typedef struct packed {
      logic [PIX_W-1:0] center;
      logic [PIX_W-1:0] north;
      logic [PIX_W-1:0] south;
      logic [PIX_W-1:0] west;
      logic [PIX_W-1:0] east;
   } adp_window_type;

   // conductance times absolute difference, conductance in unsigned q1.16
   function automatic logic [FLUX_W-1:0] flux_mag(input logic [PIX_W-1:0] a);
      logic [FLUX_W-1:0] m;
      unique case (a)
         8'd0:    m = 18'd0;
         8'd1:    m = 18'd65536;
         8'd2:    m = 18'd131038;
         8'd3:    m = 18'd194646;
         8'd4:    m = 18'd231124;
         8'd5:    m = 18'd163840;
         8'd6:    m = 18'd63834;
         8'd7:    m = 18'd21182;
         8'd8:    m = 18'd7520;
         8'd9:    m = 18'd2961;
         8'd10:   m = 18'd1280;
         8'd11:   m = 18'd594;
         8'd12:   m = 18'd300;
         8'd13:   m = 18'd156;
         8'd14:   m = 18'd84;
         8'd15:   m = 18'd45;
         8'd16:   m = 18'd32;
         8'd17:   m = 18'd17;
         8'd18:   m = 18'd18;
         default: m = 18'd0;
      endcase
      return m;
   endfunction

endpackage

FILE: rtl/core/adp_stream_if.sv
interface adp_req_if;
   logic                        valid;
   logic                        ready;
   logic [adp_pkg::PIX_W-1:0]   pixel_in;
   logic                        frame_start;

   modport source (output valid, output pixel_in, output frame_start, input ready);
   modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface adp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [adp_pkg::PIX_W-1:0]   pixel_out;
   logic                        frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

FILE: rtl/core/adp_kernel.sv
module adp_kernel (
   input  adp_pkg::adp_window_type      win,
   output logic [adp_pkg::PIX_W-1:0]    pixel_out
);

   logic [adp_pkg::PIX_W-1:0]          nb [4];
   logic signed [adp_pkg::PIX_W:0]     diff [4];
   logic [adp_pkg::PIX_W-1:0]          mag_d [4];
   logic [adp_pkg::FLUX_W-1:0]         fmag [4];
   logic signed [adp_pkg::SUM_W-1:0]   flux [4];
   logic signed [adp_pkg::SUM_W-1:0]   total;
   logic [adp_pkg::QV_W-1:0]           quot;
   logic [adp_pkg::QP_W-1:0]           prod;

   assign nb[0] = win.north;
   assign nb[1] = win.south;
   assign nb[2] = win.west;
   assign nb[3] = win.east;

   // centre scaled by 6 * 2^16, plus the four weighted differences
   always_comb begin
      total = $signed(adp_pkg::SUM_W'({win.center, 18'b0}))
            + $signed(adp_pkg::SUM_W'({win.center, 17'b0}));
      for (int i = 0; i < 4; i++) begin
         diff[i]  = $signed({1'b0, nb[i]}) - $signed({1'b0, win.center});
         mag_d[i] = diff[i][adp_pkg::PIX_W] ? adp_pkg::PIX_W'(-diff[i])
                                           : diff[i][adp_pkg::PIX_W-1:0];
         fmag[i]  = adp_pkg::flux_mag(mag_d[i]);
         flux[i]  = $signed(adp_pkg::SUM_W'(fmag[i]));
         if (diff[i][adp_pkg::PIX_W]) begin
            flux[i] = -flux[i];
         end
         total = total + flux[i];
      end
   end

   // floor divide by 3 * 2^17: shift, then reciprocal multiply
   assign quot = total[adp_pkg::DIV_SHIFT+adp_pkg::QV_W-1:adp_pkg::DIV_SHIFT];
   assign prod = adp_pkg::QP_W'(quot) * adp_pkg::QP_W'(adp_pkg::RECIP_3);

   always_comb begin
      priority if (total[adp_pkg::SUM_W-1]) begin
         pixel_out = '0;
      end else if (quot >= adp_pkg::CLAMP_V) begin
         pixel_out = '1;
      end else begin
         pixel_out = prod[adp_pkg::RECIP_SHIFT+adp_pkg::PIX_W-1:adp_pkg::RECIP_SHIFT];
      end
   end

endmodule

FILE: rtl/core/anisotropic_diffusion_pass_core.sv
// an accepted item is registered in the kernel stage, then in the output register
// throughput: one item per cycle while the output is not stalled; on the last row an
// item gives two results, and the next item waits until only one of them is left
// line buffers are read in the accept cycle, kernel runs in the next cycle
// reset: synchronous, clears counters, pipeline valids and sets the frame size to 640 x 480
module anisotropic_diffusion_pass_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [adp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [adp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   adp_req_if.sink                           req_chan,
   adp_rsp_if.source                         rsp_chan
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = AW + 1;

   logic [adp_pkg::FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [adp_pkg::FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [AW-1:0]                      column_count_ff;
   logic [adp_pkg::FRAME_HEIGHT_W-1:0] row_count_ff;
   logic [AW-1:0]                      column_count_in;
   logic [adp_pkg::FRAME_HEIGHT_W-1:0] row_count_in;

   logic [WW-1:0]                      w_eff;
   logic [adp_pkg::FRAME_HEIGHT_W-1:0] h_eff;
   logic [AW-1:0]                      x_raw;
   logic [AW-1:0]                      x;
   logic [AW-1:0]                      x_east;
   logic [adp_pkg::FRAME_HEIGHT_W-1:0] y;
   logic                               x_last;
   logic                               last_row;
   logic                               acc;

   logic [adp_pkg::PIX_W-1:0] line_prev_mem  [MAX_WIDTH];
   logic [adp_pkg::PIX_W-1:0] line_prev2_mem [MAX_WIDTH];
   logic [adp_pkg::PIX_W-1:0] rd_a_ff;
   logic [adp_pkg::PIX_W-1:0] rd_b_ff;
   logic [adp_pkg::PIX_W-1:0] rd2_ff;

   logic                      s1_valid_ff;
   logic [adp_pkg::PIX_W-1:0] s1_pix_ff;
   logic [AW-1:0]             s1_x_ff;
   logic                      s1_pass_ff;
   logic                      s1_has_res_ff;
   logic                      s1_has_echo_ff;
   logic                      s1_end_ff;
   logic                      s1_fwd_a_ff;
   logic                      s1_fwd_b_ff;
   logic                      s1_fwd2_ff;
   logic [adp_pkg::PIX_W-1:0] fwd_pix_ff;
   logic [adp_pkg::PIX_W-1:0] fwd_above_ff;
   logic [adp_pkg::PIX_W-1:0] left_pixel_ff;

   logic [adp_pkg::PIX_W-1:0] s1_above;
   logic [adp_pkg::PIX_W-1:0] s1_north;
   logic [adp_pkg::PIX_W-1:0] s1_east;
   logic [adp_pkg::PIX_W-1:0] s1_diffused;
   logic [adp_pkg::PIX_W-1:0] s1_result;
   logic                      s1_emits;
   logic                      s1_go;
   adp_pkg::adp_window_type   s1_win;

   logic                      o_has_res_ff;
   logic                      o_has_echo_ff;
   logic [adp_pkg::PIX_W-1:0] o_res_ff;
   logic [adp_pkg::PIX_W-1:0] o_echo_pix_ff;
   logic                      o_echo_end_ff;
   logic                      out_free;
   logic                      out_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= adp_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= adp_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            adp_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[adp_pkg::FRAME_WIDTH_W-1:0];
            end
            adp_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[adp_pkg::FRAME_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective frame size and position of the incoming item
   always_comb begin
      priority if (frame_width_ff < adp_pkg::FRAME_WIDTH_MIN) begin
         w_eff = WW'(3);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(frame_width_ff);
      end
      h_eff = (frame_height_ff < adp_pkg::FRAME_HEIGHT_MIN) ? adp_pkg::FRAME_HEIGHT_MIN
                                                            : frame_height_ff;
      x_raw = req_chan.frame_start ? '0 : column_count_ff;
      y     = req_chan.frame_start ? '0 : row_count_ff;
      x     = ({1'b0, x_raw} >= w_eff) ? AW'(w_eff - WW'(1)) : x_raw;
      x_last   = ({1'b0, x} == (w_eff - WW'(1)));
      last_row = (y >= (h_eff - adp_pkg::FRAME_HEIGHT_W'(1)));
      x_east   = x_last ? x : (x + AW'(1));
      if (x_last) begin
         column_count_in = '0;
         row_count_in    = last_row ? '0 : (y + adp_pkg::FRAME_HEIGHT_W'(1));
      end else begin
         column_count_in = x + AW'(1);
         row_count_in    = y;
      end
   end

   assign acc            = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else if (acc) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // line buffers: written when an item leaves the kernel stage
   always_ff @(posedge clock) begin
      if (s1_go) begin
         line_prev_mem[s1_x_ff] <= s1_pix_ff;
      end
      if (acc) begin
         rd_a_ff <= line_prev_mem[x];
         rd_b_ff <= line_prev_mem[x_east];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         line_prev2_mem[s1_x_ff] <= s1_above;
      end
      if (acc) begin
         rd2_ff <= line_prev2_mem[x];
      end
   end

   // kernel stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff      <= req_chan.pixel_in;
         s1_x_ff        <= x;
         s1_pass_ff     <= (y == adp_pkg::FRAME_HEIGHT_W'(1)) || (x == '0) || x_last;
         s1_has_res_ff  <= (y != '0);
         s1_has_echo_ff <= last_row;
         s1_end_ff      <= x_last;
         // bypass for a write of the leaving item to an address read now
         s1_fwd_a_ff    <= s1_go && (s1_x_ff == x);
         s1_fwd_b_ff    <= s1_go && (s1_x_ff == x_east);
         s1_fwd2_ff     <= s1_go && (s1_x_ff == x);
         fwd_pix_ff     <= s1_pix_ff;
         fwd_above_ff   <= s1_above;
      end
   end

   assign s1_above = s1_fwd_a_ff ? fwd_pix_ff   : rd_a_ff;
   assign s1_north = s1_fwd2_ff  ? fwd_above_ff : rd2_ff;
   assign s1_east  = s1_fwd_b_ff ? fwd_pix_ff   : rd_b_ff;

   assign s1_win.center = s1_above;
   assign s1_win.north  = s1_north;
   assign s1_win.south  = s1_pix_ff;
   assign s1_win.west   = left_pixel_ff;
   assign s1_win.east   = s1_east;

   adp_kernel u_kernel (
      .win       (s1_win),
      .pixel_out (s1_diffused)
   );

   assign s1_result = s1_pass_ff ? s1_above : s1_diffused;
   assign s1_emits  = s1_has_res_ff || s1_has_echo_ff;
   assign s1_go     = s1_valid_ff && (!s1_emits || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_pixel_ff <= '0;
      end else if (s1_go) begin
         left_pixel_ff <= s1_above;
      end
   end

   // output register, holds up to two result items of one input item
   assign out_take = rsp_chan.valid && rsp_chan.ready;
   assign out_free = !(o_has_res_ff || o_has_echo_ff)
                  || (rsp_chan.ready && (o_has_res_ff ^ o_has_echo_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         o_has_res_ff  <= 1'b0;
         o_has_echo_ff <= 1'b0;
      end else if (s1_go && s1_emits) begin
         o_has_res_ff  <= s1_has_res_ff;
         o_has_echo_ff <= s1_has_echo_ff;
      end else if (out_take) begin
         if (o_has_res_ff) begin
            o_has_res_ff <= 1'b0;
         end else begin
            o_has_echo_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emits) begin
         o_res_ff      <= s1_result;
         o_echo_pix_ff <= s1_pix_ff;
         o_echo_end_ff <= s1_end_ff;
      end
   end

   assign rsp_chan.valid     = o_has_res_ff || o_has_echo_ff;
   assign rsp_chan.pixel_out = o_has_res_ff ? o_res_ff : o_echo_pix_ff;
   assign rsp_chan.frame_end = o_has_res_ff ? 1'b0 : o_echo_end_ff;

endmodule

FILE: rtl/core/adp_checker.sv
`include "anisotropic_diffusion_pass_core_defines.svh"

module adp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [adp_pkg::PIX_W-1:0]   pixel_out,
   input logic                        frame_end
);

   logic req_acc;

   assign req_acc = req_valid && req_ready;

   `ADP_ASSERT_RESET(a_no_rsp_after_reset, !rsp_valid, "result item shown right after reset")
   `ADP_ASSERT_SAME(a_ready_when_out_empty, !rsp_valid, req_ready, "input stalled with empty output")
   `ADP_ASSERT_NEXT(a_no_rsp_from_nothing, (!rsp_valid && !req_acc) ##1 !rsp_valid, !rsp_valid, "result item without a pending item")
   `ADP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(pixel_out) && $stable(frame_end), "stalled result item changed")

endmodule

bind anisotropic_diffusion_pass_core adp_checker u_adp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .pixel_out (rsp_chan.pixel_out),
   .frame_end (rsp_chan.frame_end)
);

FILE: sim/tb_anisotropic_diffusion_pass_core.sv
`timescale 1ns / 100ps

module tb_anisotropic_diffusion_pass_core;

   localparam int              LINE_DEPTH    = 1024;
   localparam longint unsigned ONE_Q16       = 65536;
   localparam longint unsigned KNEE_POW9     = 1953125;
   localparam longint          SIXTH_SCALE   = 6 * 65536;
   localparam int unsigned     CUTOFF_DIFF   = 19;
   localparam int              SETTLE_CYCLES = 8;
   localparam int              RANDOM_ITEMS  = 200;

   typedef struct packed {
      logic [adp_pkg::PIX_W-1:0] pixel;
      logic                      start;
   } pixel_item_type;

   typedef struct packed {
      logic [adp_pkg::PIX_W-1:0] pixel;
      logic                      frame_end;
   } diffused_type;

   typedef enum int {TEX_SMOOTH, TEX_NOISE, TEX_EXTREME} texture_type;
   typedef enum int {SINK_OPEN, SINK_JITTER, SINK_LONG_STALL, SINK_ALTERNATE} sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_we    = 1'b0;
   logic [adp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [adp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic                      drv_valid  = 1'b0;
   logic [adp_pkg::PIX_W-1:0] drv_pixel  = '0;
   logic                      drv_start  = 1'b0;
   logic                      sink_ready = 1'b0;

   adp_req_if req_chan();
   adp_rsp_if rsp_chan();

   assign req_chan.valid       = drv_valid;
   assign req_chan.pixel_in    = drv_pixel;
   assign req_chan.frame_start = drv_start;
   assign rsp_chan.ready       = sink_ready;

   anisotropic_diffusion_pass_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #2 clock = ~clock;

   // stimulus and expectations
   pixel_item_type pixel_pending[$];
   diffused_type   diffused_q[$];
   int             pushed_count   = 0;
   int             accepted_count = 0;
   int             mismatch_count = 0;

   // shadow of the block state
   logic [adp_pkg::FRAME_WIDTH_W-1:0]  shadow_width  = adp_pkg::FRAME_WIDTH_RESET;
   logic [adp_pkg::FRAME_HEIGHT_W-1:0] shadow_height = adp_pkg::FRAME_HEIGHT_RESET;
   bit [adp_pkg::PIX_W-1:0]            row_above  [LINE_DEPTH];
   bit [adp_pkg::PIX_W-1:0]            row_above2 [LINE_DEPTH];
   int unsigned                        shadow_col  = 0;
   int unsigned                        shadow_row  = 0;
   bit [adp_pkg::PIX_W-1:0]            shadow_left = '0;

   function automatic int unsigned lane_width(int unsigned v);
      if (v < 3) return 3;
      if (v > LINE_DEPTH) return LINE_DEPTH;
      return v;
   endfunction

   function automatic int unsigned lane_height(int unsigned v);
      if (v < 3) return 3;
      return v;
   endfunction

   // conductance 1/(1+(d/5)^9) in unsigned q1.16, rounded half up
   function automatic longint unsigned conductance_q16(int unsigned d);
      longint unsigned p;
      longint unsigned num;
      longint unsigned den;
      if (d >= CUTOFF_DIFF) return 0;
      p = 1;
      for (int i = 0; i < 9; i++) p = p * d;
      num = ONE_Q16 * KNEE_POW9;
      den = KNEE_POW9 + p;
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic longint weighted_diff(int nb, int ctr);
      int          d;
      int unsigned a;
      d = nb - ctr;
      a = (d < 0) ? -d : d;
      return longint'(conductance_q16(a)) * longint'(d);
   endfunction

   function automatic logic [adp_pkg::PIX_W-1:0] diffused_value(int c, int n, int s, int w,
                                                                 int e);
      longint t;
      longint q;
      t = longint'(c) * SIXTH_SCALE + weighted_diff(n, c) + weighted_diff(s, c)
          + weighted_diff(w, c) + weighted_diff(e, c);
      if (t < 0) return '0;
      q = t / SIXTH_SCALE;
      if (q > 255) return '1;
      return q[adp_pkg::PIX_W-1:0];
   endfunction

   function automatic void absorb_pixel(logic [adp_pkg::PIX_W-1:0] pix, logic start);
      int unsigned             w;
      int unsigned             h;
      int unsigned             x;
      int unsigned             y;
      bit [adp_pkg::PIX_W-1:0] above;
      bit [adp_pkg::PIX_W-1:0] above2;
      bit [adp_pkg::PIX_W-1:0] res;
      bit                      last_row;
      w = lane_width(shadow_width);
      h = lane_height(shadow_height);
      if (start) begin
         shadow_col = 0;
         shadow_row = 0;
      end
      x = shadow_col;
      y = shadow_row;
      if (x >= w) x = w - 1;
      last_row = (y + 1 >= h);
      above    = row_above[x];
      above2   = row_above2[x];
      if (y != 0) begin
         if (y == 1 || x == 0 || x + 1 >= w) res = above;
         else res = diffused_value(above, above2, pix, shadow_left, row_above[x+1]);
         diffused_q.push_back('{pixel: res, frame_end: 1'b0});
      end
      // last row is echoed as it arrives
      if (last_row) diffused_q.push_back('{pixel: pix, frame_end: (x + 1 >= w)});
      shadow_left   = above;
      row_above2[x] = above;
      row_above[x]  = pix;
      if (x + 1 >= w) begin
         shadow_col = 0;
         shadow_row = last_row ? 0 : y + 1;
      end else begin
         shadow_col = x + 1;
      end
   endfunction

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
         gap_left   = 0;
         burst_left = $urandom_range(1, 40);
      end else if (!drv_valid || req_chan.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            drv_valid <= 1'b0;
         end else if (pixel_pending.size() != 0) begin
            pixel_item_type it;
            it = pixel_pending.pop_front();
            drv_pixel <= it.pixel;
            drv_start <= it.start;
            drv_valid <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern
   sink_mode_type sink_mode       = SINK_OPEN;
   int            sink_mode_left  = 0;
   int            sink_stall_left = 0;

   always @(posedge clock) begin
      if (sink_mode_left == 0) begin
         sink_mode      = sink_mode_type'($urandom_range(0, 3));
         sink_mode_left = $urandom_range(64, 512);
      end else begin
         sink_mode_left--;
      end
      if (sink_stall_left > 0) begin
         sink_stall_left--;
         sink_ready <= 1'b0;
      end else begin
         case (sink_mode)
            SINK_OPEN: begin
               sink_ready <= 1'b1;
            end
            SINK_JITTER: begin
               if ($urandom_range(0, 2) == 0) begin
                  sink_stall_left = $urandom_range(0, 2);
                  sink_ready <= 1'b0;
               end else begin
                  sink_ready <= 1'b1;
               end
            end
            SINK_LONG_STALL: begin
               if ($urandom_range(0, 7) == 0) begin
                  sink_stall_left = $urandom_range(3, 11);
                  sink_ready <= 1'b0;
               end else begin
                  sink_ready <= 1'b1;
               end
            end
            default: begin
               sink_ready <= ~sink_ready;
            end
         endcase
      end
   end

   // monitor
   diffused_type mon_want;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            absorb_pixel(req_chan.pixel_in, req_chan.frame_start);
            accepted_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (diffused_q.size() == 0) begin
               $error("unexpected result item: pixel_out %0d frame_end %0b",
                      rsp_chan.pixel_out, rsp_chan.frame_end);
               mismatch_count++;
            end else begin
               mon_want = diffused_q.pop_front();
               if (rsp_chan.pixel_out !== mon_want.pixel) begin
                  $error("pixel_out: expected %0d, got %0d", mon_want.pixel,
                         rsp_chan.pixel_out);
                  mismatch_count++;
               end
               if (rsp_chan.frame_end !== mon_want.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", mon_want.frame_end,
                         rsp_chan.frame_end);
                  mismatch_count++;
               end
            end
         end
      end
   end

   function automatic void push_item(logic [adp_pkg::PIX_W-1:0] pix, logic start);
      pixel_pending.push_back('{pixel: pix, start: start});
      pushed_count++;
   endfunction

   function automatic void push_frame(int unsigned count, bit with_start, texture_type tex,
                                      bit noise);
      int   base;
      int   v;
      logic st;
      base = $urandom_range(0, 255);
      for (int unsigned i = 0; i < count; i++) begin
         case (tex)
            TEX_SMOOTH: begin
               v = base + int'($urandom_range(0, 20)) - 10;
               if (v < 0) v = 0;
               if (v > 255) v = 255;
               base = v;
            end
            TEX_NOISE: begin
               v = $urandom_range(0, 255);
            end
            default: begin
               v = $urandom_range(0, 1) ? $urandom_range(247, 255) : $urandom_range(0, 8);
            end
         endcase
         st = (with_start && i == 0) || (noise && $urandom_range(0, 149) == 0);
         push_item(v[adp_pkg::PIX_W-1:0], st);
      end
   endfunction

   task automatic write_reg(logic [adp_pkg::CSR_IDX_W-1:0] idx,
                            logic [adp_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == adp_pkg::REG_FRAME_WIDTH) shadow_width = data[adp_pkg::FRAME_WIDTH_W-1:0];
      else shadow_height = data[adp_pkg::FRAME_HEIGHT_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_and_settle();
      do @(negedge clock);
      while (accepted_count != pushed_count || diffused_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned                    random_items;
      int unsigned                    pick;
      int unsigned                    eff_w;
      int unsigned                    eff_h;
      int unsigned                    nframes;
      int unsigned                    count;
      logic [adp_pkg::CSR_DATA_W-1:0] wreg;
      logic [adp_pkg::CSR_DATA_W-1:0] hreg;
      random_items = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset frame size, one row and a bit, fills the start of both line stores
      push_frame(680, 1'b1, TEX_SMOOTH, 1'b0);
      drain_and_settle();

      // width beyond the line store, one row and a bit
      write_reg(adp_pkg::REG_FRAME_WIDTH, 12'hFFF);
      push_frame(1032, 1'b1, TEX_NOISE, 1'b0);
      drain_and_settle();

      // smallest frames
      write_reg(adp_pkg::REG_FRAME_WIDTH, 12'd3);
      write_reg(adp_pkg::REG_FRAME_HEIGHT, 12'd3);
      push_item(8'd14, 1'b1); push_item(8'd14, 1'b0); push_item(8'd14, 1'b0);
      push_item(8'd14, 1'b0); push_item(8'd10, 1'b0); push_item(8'd14, 1'b0);
      push_item(8'd0, 1'b0);  push_item(8'd14, 1'b0); push_item(8'd255, 1'b0);
      // next frame wraps on its own
      push_item(8'd0, 1'b0);   push_item(8'd255, 1'b0); push_item(8'd0, 1'b0);
      push_item(8'd255, 1'b0); push_item(8'd255, 1'b0); push_item(8'd255, 1'b0);
      push_item(8'd251, 1'b0); push_item(8'd0, 1'b0);   push_item(8'd255, 1'b0);
      // restart in mid row, left unfinished
      push_item(8'd1, 1'b1);   push_item(8'd2, 1'b0);
      push_item(8'd245, 1'b1); push_item(8'd240, 1'b0); push_item(8'd250, 1'b0);
      push_item(8'd243, 1'b0);
      drain_and_settle();

      // tallest frame, a few rows
      write_reg(adp_pkg::REG_FRAME_WIDTH, 12'h803);
      write_reg(adp_pkg::REG_FRAME_HEIGHT, 12'hFFF);
      push_frame(15, 1'b1, TEX_EXTREME, 1'b0);
      drain_and_settle();

      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) wreg = adp_pkg::CSR_DATA_W'($urandom_range(3, 12));
         else if (pick == 8) wreg = adp_pkg::CSR_DATA_W'($urandom_range(0, 2));
         else wreg = adp_pkg::CSR_DATA_W'($urandom_range(13, 40));
         if ($urandom_range(0, 1)) wreg[adp_pkg::CSR_DATA_W-1] = 1'b1;
         pick = $urandom_range(0, 9);
         if (pick < 8) hreg = adp_pkg::CSR_DATA_W'($urandom_range(3, 6));
         else if (pick == 8) hreg = adp_pkg::CSR_DATA_W'($urandom_range(0, 2));
         else hreg = adp_pkg::CSR_DATA_W'($urandom_range(7, 10));
         if ($urandom_range(0, 1)) begin
            write_reg(adp_pkg::REG_FRAME_WIDTH, wreg);
            write_reg(adp_pkg::REG_FRAME_HEIGHT, hreg);
         end else begin
            write_reg(adp_pkg::REG_FRAME_HEIGHT, hreg);
            write_reg(adp_pkg::REG_FRAME_WIDTH, wreg);
         end
         eff_w   = lane_width(wreg[adp_pkg::FRAME_WIDTH_W-1:0]);
         eff_h   = lane_height(hreg);
         nframes = $urandom_range(1, 4);
         for (int unsigned f = 0; f < nframes && random_items < RANDOM_ITEMS; f++) begin
            pick  = $urandom_range(0, 9);
            count = eff_w * eff_h;
            if (pick == 9) count = $urandom_range(1, count - 1);
            push_frame(count, pick != 8, texture_type'($urandom_range(0, 2)),
                       $urandom_range(0, 3) == 0);
            random_items += count;
         end
         drain_and_settle();
      end

      if (mismatch_count == 0 && diffused_q.size() == 0) begin
         $display("tb_anisotropic_diffusion_pass_core: done, clean");
      end else begin
         $display("tb_anisotropic_diffusion_pass_core: done, errors");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("tb_anisotropic_diffusion_pass_core: done, errors");
      $finish;
   end

endmodule
